/* sv/ble_pkg.sv */
package ble_pkg;

  localparam int AdcW = 12;
  localparam int MvW  = 14;
  localparam int VoltW = 17;
  localparam int LvlW = 7;

  localparam logic [2:0] CFG_FULL_ADC  = 3'd0;
  localparam logic [2:0] CFG_EMPTY_ADC = 3'd1;
  localparam logic [2:0] CFG_FULL_MV   = 3'd2;
  localparam logic [2:0] CFG_KNEE_MV   = 3'd3;
  localparam logic [2:0] CFG_EMPTY_MV  = 3'd4;
  localparam logic [2:0] CFG_OFFSET_MV = 3'd5;
  localparam logic [2:0] CFG_HOLD      = 3'd6;

  localparam logic [1:0] PINS_NONE     = 2'd0;
  localparam logic [1:0] PINS_FULL     = 2'd1;
  localparam logic [1:0] PINS_CHARGING = 2'd2;
  localparam logic [1:0] PINS_IDLE     = 2'd3;

  localparam logic [1:0] SRC_BATTERY   = 2'd0;
  localparam logic [1:0] SRC_CHARGER   = 2'd1;
  localparam logic [1:0] SRC_DISCHARGE = 2'd2;

  localparam logic [1:0] STAT_NOT_CHARGING = 2'd0;
  localparam logic [1:0] STAT_CHARGING     = 2'd1;
  localparam logic [1:0] STAT_FULL         = 2'd2;
  localparam logic [1:0] STAT_DISCHARGING  = 2'd3;

  // Datapath operations selected by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RING,
    OP_SUM,
    OP_AVG_DIV,
    OP_VOLT_DIV,
    OP_VOLT_FIN,
    OP_LVL_DIV,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sum_last;
  } dp_sts_t;

endpackage

/* sv/ble_div.sv */
// Restoring signed divider truncating toward zero; zero divisor gives zero.
module ble_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] num,
  input  logic signed [39:0] den,
  output logic               done,
  output logic signed [39:0] quo
);
  logic [39:0] n_r, n_nxt, d_r, d_nxt, q_r, q_nxt;
  logic [40:0] rem_r, rem_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;

  always_comb begin
    n_nxt = n_r; d_nxt = d_r; q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    neg_nxt = neg_r; busy_nxt = busy_r; done_nxt = 1'b0; zero_nxt = zero_r;
    trial = '0;
    if (start) begin
      n_nxt = num[39] ? 40'(-num) : num;
      d_nxt = den[39] ? 40'(-den) : den;
      neg_nxt = num[39] ^ den[39];
      zero_nxt = (den == '0);
      rem_nxt = '0; q_nxt = '0; cnt_nxt = 6'd40; busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[39:0], n_r[39]};
      n_nxt = {n_r[38:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
    cnt_r <= cnt_nxt; neg_r <= neg_nxt; zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : (neg_r ? 40'(-q_r) : q_r);
endmodule

/* sv/ble_ctrl.sv */
module ble_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ble_pkg::dp_cmd_t  cmd,
  input  ble_pkg::dp_sts_t  sts
);
  import ble_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_SUM, S_AVG, S_VOLT, S_VOLT_W, S_VFIN,
    S_LVL, S_LVL_W, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    cmd.div_start = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD;
        state_nxt = S_RING;
      end
      S_RING: begin
        cmd.op = OP_RING;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        if (sts.sum_last) state_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.op = OP_AVG_DIV;
        state_nxt = S_VOLT;
      end
      S_VOLT: begin
        cmd.op = OP_VOLT_DIV;
        cmd.div_start = 1'b1;
        state_nxt = S_VOLT_W;
      end
      S_VOLT_W: if (sts.div_done) begin
        cmd.op = OP_VOLT_DIV;
        state_nxt = S_VFIN;
      end
      S_VFIN: begin
        cmd.op = OP_VOLT_FIN;
        state_nxt = S_LVL;
      end
      S_LVL: begin
        cmd.op = OP_LVL_DIV;
        cmd.div_start = 1'b1;
        state_nxt = S_LVL_W;
      end
      S_LVL_W: if (sts.div_done) begin
        cmd.op = OP_LVL_DIV;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
endmodule

/* sv/ble_dp.sv */
module ble_dp #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ble_pkg::dp_cmd_t              cmd,
  output ble_pkg::dp_sts_t              sts,
  input  logic [11:0]                   in_adc_sample,
  input  logic [1:0]                    in_charger_pins,
  input  logic [11:0]                   full_adc,
  input  logic [11:0]                   empty_adc,
  input  logic [13:0]                   full_mv,
  input  logic [13:0]                   knee_mv,
  input  logic [13:0]                   empty_mv,
  input  logic [9:0]                    charge_offset_mv,
  input  logic [7:0]                    hold_polls,
  output logic [11:0]                   out_avg_adc,
  output logic signed [16:0]            out_voltage_mv,
  output logic [6:0]                    out_level_pct,
  output logic                          out_is_full,
  output logic [1:0]                    out_source,
  output logic [1:0]                    out_supply_status
);
  import ble_pkg::*;

  localparam int PosW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SumW = AdcW + $clog2(WINDOW_LEN + 1);

  // The window average multiplies by a rounded-up reciprocal of WINDOW_LEN.
  // The shift is wide enough that the quotient is exact for every ring sum.
  localparam int RecipSh = 24;
  localparam int RecipW  = RecipSh + 1;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << RecipSh) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam int ProdW = SumW + RecipW;

  logic [AdcW-1:0] ring_r [WINDOW_LEN];
  logic [PosW-1:0] pos_r, idx_r;
  logic            refill_r, refilled_r;
  logic [1:0]      last_pins_r, pins_r;
  logic [7:0]      hold_r;
  logic [LvlW-1:0] lvl_r;
  logic            full_r;
  logic [AdcW-1:0] sample_r, avg_r;
  logic [SumW-1:0] sum_r;
  logic signed [VoltW-1:0] volt_r;
  logic signed [39:0] quo_r;
  logic            held_r, above_knee_r;

  logic signed [39:0] div_num, div_den, div_q;
  logic               div_done;

  ble_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(div_num), .den(div_den), .done(div_done), .quo(div_q)
  );

  logic signed [13:0] adc_diff;
  logic signed [15:0] mv_span;
  logic signed [31:0] volt_prod;
  logic [ProdW-1:0]   avg_prod;
  logic signed [19:0] lv_delta;
  logic signed [27:0] lv_prod;
  logic signed [41:0] volt_raw;
  logic signed [VoltW-1:0] volt_sat;
  logic signed [41:0] lv_raw;
  logic [LvlW-1:0] lvl_calc, lvl_o;
  logic            full_calc, full_o;
  logic [1:0]      src_o;

  always_comb begin
    adc_diff  = $signed({2'b0, avg_r}) - $signed({2'b0, empty_adc});
    mv_span   = $signed({2'b0, full_mv}) - $signed({2'b0, empty_mv});
    volt_prod = 32'(adc_diff) * 32'(mv_span);
    avg_prod  = ProdW'(sum_r) * ProdW'(RecipM);
  end

  always_comb begin
    div_num = '0;
    div_den = '0;
    lv_delta = above_knee_r ? (20'(volt_r) - $signed({6'b0, knee_mv}))
                            : (20'(volt_r) - $signed({6'b0, empty_mv}));
    lv_prod = above_knee_r ? 28'(lv_delta) * 28'sd85 : 28'(lv_delta) * 28'sd15;
    case (cmd.op)
      OP_VOLT_DIV: begin
        div_num = 40'(volt_prod);
        div_den = 40'($signed({2'b0, full_adc}) - $signed({2'b0, empty_adc}));
      end
      OP_LVL_DIV: begin
        div_num = 40'(lv_prod);
        div_den = above_knee_r
          ? 40'($signed({2'b0, full_mv}) - $signed({2'b0, knee_mv}))
          : 40'($signed({2'b0, knee_mv}) - $signed({2'b0, empty_mv}));
      end
      default: ;
    endcase
  end

  always_comb begin
    volt_raw = 42'(quo_r) + 42'($signed({1'b0, empty_mv}));
    if (pins_r == PINS_CHARGING) volt_raw = volt_raw - 42'($signed({1'b0, charge_offset_mv}));
    if (volt_raw < -42'sd65536) volt_sat = -17'sd65536;
    else if (volt_raw > 42'sd65535) volt_sat = 17'sd65535;
    else volt_sat = volt_raw[VoltW-1:0];

    lv_raw = 42'(div_q) + (above_knee_r ? 42'sd15 : 42'sd0);
    if (lv_raw < 0) lvl_calc = '0;
    else if (lv_raw > 42'sd100) lvl_calc = 7'd100;
    else lvl_calc = lv_raw[LvlW-1:0];

    lvl_o = lvl_r;
    full_o = full_r;
    full_calc = 1'b0;
    if (!held_r) begin
      if (avg_r >= full_adc) begin
        full_o = 1'b1; lvl_o = 7'd100;
      end else begin
        full_o = full_calc; lvl_o = quo_r[LvlW-1:0];
      end
      if (avg_r <= empty_adc) begin
        full_o = 1'b0; lvl_o = '0;
      end
    end
    case (pins_r)
      PINS_FULL: begin
        src_o = SRC_DISCHARGE; full_o = 1'b1; lvl_o = 7'd100;
      end
      PINS_CHARGING: begin
        src_o = SRC_CHARGER; full_o = 1'b0;
        if (lvl_o >= 7'd100) lvl_o = 7'd99;
        if (avg_r <= empty_adc) lvl_o = 7'd1;
      end
      PINS_IDLE: src_o = SRC_DISCHARGE;
      default:   src_o = SRC_BATTERY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; refill_r <= 1'b1; last_pins_r <= '0; hold_r <= '0;
      lvl_r <= '0; full_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          sample_r <= in_adc_sample;
          pins_r <= in_charger_pins;
        end
        OP_RING: begin
          refilled_r <= refill_r;
          if (refill_r) begin
            for (int i = 0; i < WINDOW_LEN; i++) ring_r[i] <= sample_r;
            pos_r <= '0;
            refill_r <= 1'b0;
          end else begin
            ring_r[pos_r] <= sample_r;
            pos_r <= (32'(pos_r) + 1 >= WINDOW_LEN) ? '0 : PosW'(pos_r + 1'b1);
          end
          idx_r <= '0;
          sum_r <= '0;
        end
        OP_SUM: begin
          sum_r <= sum_r + SumW'(ring_r[idx_r]);
          idx_r <= PosW'(idx_r + 1'b1);
        end
        OP_AVG_DIV: avg_r <= refilled_r ? sample_r : avg_prod[RecipSh +: AdcW];
        OP_VOLT_DIV: if (div_done) quo_r <= div_q;
        OP_VOLT_FIN: begin
          volt_r <= volt_sat;
          above_knee_r <= (volt_sat >= $signed({3'b0, knee_mv}));
          if (pins_r != last_pins_r) begin
            refill_r <= 1'b1;
            last_pins_r <= pins_r;
            held_r <= (hold_polls != 8'd0);
            hold_r <= (hold_polls != 8'd0) ? hold_polls - 8'd1 : 8'd0;
          end else begin
            held_r <= (hold_r != 8'd0);
            if (hold_r != 8'd0) hold_r <= hold_r - 8'd1;
          end
        end
        OP_LVL_DIV: if (div_done) quo_r <= 40'(lvl_calc);
        OP_FINISH: begin
          lvl_r <= lvl_o;
          full_r <= full_o;
          out_source <= src_o;
          if (src_o == SRC_BATTERY) out_supply_status <= STAT_NOT_CHARGING;
          else if (src_o == SRC_DISCHARGE) out_supply_status <= STAT_DISCHARGING;
          else out_supply_status <= (lvl_o == 7'd100 && full_o) ? STAT_FULL : STAT_CHARGING;
        end
        default: ;
      endcase
    end
  end

  assign sts.div_done = div_done;
  assign sts.sum_last = (32'(idx_r) == WINDOW_LEN - 1);
  assign out_avg_adc    = avg_r;
  assign out_voltage_mv = volt_r;
  assign out_level_pct  = lvl_r;
  assign out_is_full    = full_r;
endmodule

/* sv/battery_level_estimator_core.sv */
// Battery level estimator: one result per accepted poll. The time from
// acceptance to result is set by the ring sum over WINDOW_LEN samples and
// two passes through one shared 40-step serial divider (voltage map, level
// curve). The input is stalled while a poll is in work or its result is
// not taken, so a new poll is accepted only after the last result is taken.
module battery_level_estimator_core #(
  parameter int WINDOW_LEN = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_adc_sample,
  input  logic [1:0]         in_charger_pins,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_avg_adc,
  output logic signed [16:0] out_voltage_mv,
  output logic [6:0]         out_level_pct,
  output logic               out_is_full,
  output logic [1:0]         out_source,
  output logic [1:0]         out_supply_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [13:0]        cfg_data
);
  import ble_pkg::*;

  logic [11:0] full_adc_r, empty_adc_r;
  logic [13:0] full_mv_r, knee_mv_r, empty_mv_r;
  logic [9:0]  offset_r;
  logic [7:0]  hold_polls_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_adc_r <= 12'd3000; empty_adc_r <= 12'd2217;
      full_mv_r <= 14'd8400; knee_mv_r <= 14'd7091; empty_mv_r <= 14'd6000;
      offset_r <= 10'd220; hold_polls_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_ADC:  full_adc_r <= cfg_data[11:0];
        CFG_EMPTY_ADC: empty_adc_r <= cfg_data[11:0];
        CFG_FULL_MV:   full_mv_r <= cfg_data;
        CFG_KNEE_MV:   knee_mv_r <= cfg_data;
        CFG_EMPTY_MV:  empty_mv_r <= cfg_data;
        CFG_OFFSET_MV: offset_r <= cfg_data[9:0];
        CFG_HOLD:      hold_polls_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ble_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  ble_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_adc_sample(in_adc_sample), .in_charger_pins(in_charger_pins),
    .full_adc(full_adc_r), .empty_adc(empty_adc_r), .full_mv(full_mv_r),
    .knee_mv(knee_mv_r), .empty_mv(empty_mv_r), .charge_offset_mv(offset_r),
    .hold_polls(hold_polls_r),
    .out_avg_adc(out_avg_adc), .out_voltage_mv(out_voltage_mv),
    .out_level_pct(out_level_pct), .out_is_full(out_is_full),
    .out_source(out_source), .out_supply_status(out_supply_status)
  );
endmodule
